[design/csescan_pkg.sv]
// Shared types and constants of the code segment entry scanner.
package csescan_pkg;

	localparam logic [7:0]  OPC_HI      = 8'h20;
	localparam logic [7:0]  OPC_LO      = 8'h5F;
	localparam logic [31:0] JT_HDR_LEN  = 32'd16;
	localparam logic [31:0] SEG_HDR_LEN = 32'd4;
	localparam logic [31:0] OFF_MAX     = 32'hFFFF_FFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_META  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_CODE  = 2'd2;
	localparam logic [1:0] KIND_DEFER = 2'd3;

	localparam logic [2:0] EV_JT_HDR  = 3'd0;
	localparam logic [2:0] EV_SEG_HDR = 3'd1;
	localparam logic [2:0] EV_PREFIX  = 3'd2;
	localparam logic [2:0] EV_STACK   = 3'd3;
	localparam logic [2:0] EV_MISSING = 3'd4;

	// Summary of one finished payload, handed from the scanner to the emitter.
	typedef struct packed {
		logic        is_zero;
		logic        found;
		logic [31:0] size;
		logic [31:0] entry_off;
		logic [31:0] hw_a;
		logic [31:0] hw_b;
		logic [31:0] hw_c;
		logic [31:0] hw_d;
	} seg_rec_t;

	// Queue handshake between the two halves.
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

[design/csescan_front.sv]
// Byte scanner: tracks offset, header words and the entry pattern of each payload.
module csescan_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic signed [15:0]    segment_id,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  push,
	output csescan_pkg::seg_rec_t push_rec
);

	logic [31:0] count_q;
	logic [31:0] hdr_q [4];
	logic        zero_q;
	logic        prior_q;
	logic        found_q;
	logic [31:0] eoff_q;

	logic        take;
	logic [31:0] off;
	logic [31:0] size;
	logic        zero_now;
	logic        hit;
	logic        found_now;
	logic [31:0] eoff_now;
	logic [31:0] hdr_next [4];

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign off      = count_q;
	assign size     = (off == csescan_pkg::OFF_MAX) ? off : off + 32'd1;
	assign zero_now = (off == 32'd0) ? (segment_id == 16'sd0) : zero_q;

	// Only an odd offset can close the pair, and only the first match counts.
	assign hit = (off >= csescan_pkg::SEG_HDR_LEN) && off[0] && prior_q &&
		(data_byte == csescan_pkg::OPC_LO) && !found_q;
	assign found_now = found_q || hit;
	assign eoff_now  = found_q ? eoff_q : off - 32'd1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if ((off < csescan_pkg::JT_HDR_LEN) && (off[3:2] == 2'(i))) begin
				hdr_next[i] = {hdr_q[i][23:0], data_byte};
			end else begin
				hdr_next[i] = hdr_q[i];
			end
		end
	end

	always_comb begin
		push_rec.is_zero   = zero_now;
		push_rec.found     = found_now;
		push_rec.size      = size;
		push_rec.entry_off = eoff_now;
		if (zero_now) begin
			if (size >= csescan_pkg::JT_HDR_LEN) begin
				push_rec.hw_a = hdr_next[0];
				push_rec.hw_b = hdr_next[1];
				push_rec.hw_c = hdr_next[2];
				push_rec.hw_d = hdr_next[3];
			end else begin
				push_rec.hw_a = '0;
				push_rec.hw_b = '0;
				push_rec.hw_c = '0;
				push_rec.hw_d = '0;
			end
		end else begin
			push_rec.hw_a = {16'd0, hdr_next[0][31:16]};
			push_rec.hw_b = {16'd0, hdr_next[0][15:0]};
			push_rec.hw_c = '0;
			push_rec.hw_d = '0;
		end
	end

	assign push = take && last_byte &&
		(zero_now || (size >= csescan_pkg::SEG_HDR_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			zero_q  <= 1'b0;
			prior_q <= 1'b0;
			found_q <= 1'b0;
			eoff_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (take) begin
			if (last_byte) begin
				count_q <= '0;
				zero_q  <= 1'b0;
				prior_q <= 1'b0;
				found_q <= 1'b0;
				eoff_q  <= '0;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				count_q <= size;
				zero_q  <= zero_now;
				found_q <= found_now;
				eoff_q  <= eoff_now;
				if ((off >= csescan_pkg::SEG_HDR_LEN) && !off[0]) begin
					prior_q <= (data_byte == csescan_pkg::OPC_HI);
				end
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= hdr_next[i];
				end
			end
		end
	end

endmodule

[design/csescan_queue.sv]
// Short queue of payload summaries between the scanner and the range emitter.
module csescan_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csescan_pkg::q_ctrl_t  ctrl,
	input  csescan_pkg::seg_rec_t push_rec,
	output csescan_pkg::q_stat_t  stat,
	output csescan_pkg::seg_rec_t head_rec
);

	csescan_pkg::seg_rec_t             slot_q [csescan_pkg::QUEUE_DEPTH];
	logic [csescan_pkg::QPTR_W-1:0]    wr_q;
	logic [csescan_pkg::QPTR_W-1:0]    rd_q;
	logic [csescan_pkg::QPTR_W:0]      cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign stat.full      = (cnt_q == (csescan_pkg::QPTR_W+1)'(csescan_pkg::QUEUE_DEPTH));
	assign stat.not_empty = (cnt_q != '0);
	assign head_rec       = slot_q[rd_q];
	assign do_push        = ctrl.push && !stat.full;
	assign do_pop         = ctrl.pop && stat.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/csescan_back.sv]
// Range emitter: turns each payload summary into one to three output beats.
module csescan_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  csescan_pkg::seg_rec_t head_rec,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            range_kind,
	output logic [2:0]            range_evidence,
	output logic [31:0]           range_start,
	output logic [31:0]           range_size,
	output logic                  is_entry,
	output logic [31:0]           header_word_a,
	output logic [31:0]           header_word_b,
	output logic [31:0]           header_word_c,
	output logic [31:0]           header_word_d,
	output logic                  last_range
);

	localparam logic [1:0] ST_HDR  = 2'd0;
	localparam logic [1:0] ST_BODY = 2'd1;
	localparam logic [1:0] ST_CODE = 2'd2;

	logic [1:0]  step_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  ev_q;
	logic [31:0] start_q;
	logic [31:0] size_q;
	logic        entry_q;
	logic [31:0] hw_a_q;
	logic [31:0] hw_b_q;
	logic [31:0] hw_c_q;
	logic [31:0] hw_d_q;
	logic        last_q;

	logic        emit;
	logic [1:0]  step_d;
	logic [1:0]  kind_d;
	logic [2:0]  ev_d;
	logic [31:0] start_d;
	logic [31:0] size_d;
	logic        entry_d;
	logic        last_d;
	logic        out_free;
	logic        load;

	always_comb begin
		emit    = 1'b1;
		step_d  = ST_HDR;
		kind_d  = csescan_pkg::KIND_CODE;
		ev_d    = csescan_pkg::EV_STACK;
		start_d = head_rec.entry_off;
		size_d  = head_rec.size - head_rec.entry_off;
		entry_d = 1'b1;
		last_d  = 1'b1;
		unique case (step_q)
			ST_HDR: begin
				kind_d  = csescan_pkg::KIND_META;
				ev_d    = head_rec.is_zero ? csescan_pkg::EV_JT_HDR : csescan_pkg::EV_SEG_HDR;
				start_d = '0;
				size_d  = head_rec.is_zero ? head_rec.size : csescan_pkg::SEG_HDR_LEN;
				entry_d = 1'b0;
				last_d  = head_rec.is_zero || (head_rec.size == csescan_pkg::SEG_HDR_LEN);
				step_d  = ST_BODY;
			end
			ST_BODY: begin
				if (!head_rec.found) begin
					kind_d  = csescan_pkg::KIND_DEFER;
					ev_d    = csescan_pkg::EV_MISSING;
					start_d = csescan_pkg::SEG_HDR_LEN;
					size_d  = head_rec.size - csescan_pkg::SEG_HDR_LEN;
					entry_d = 1'b0;
				end else if (head_rec.entry_off > csescan_pkg::SEG_HDR_LEN) begin
					kind_d  = csescan_pkg::KIND_DATA;
					ev_d    = csescan_pkg::EV_PREFIX;
					start_d = csescan_pkg::SEG_HDR_LEN;
					size_d  = head_rec.entry_off - csescan_pkg::SEG_HDR_LEN;
					entry_d = 1'b0;
					last_d  = 1'b0;
					step_d  = ST_CODE;
				end
			end
			ST_CODE: begin
				step_d = ST_HDR;
			end
			default: begin
				emit   = 1'b0;
				last_d = 1'b0;
				step_d = ST_HDR;
			end
		endcase
	end

	assign out_free = !valid_q || !out_stall;
	assign load     = q_not_empty && out_free && emit;
	assign pop      = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_HDR;
			valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= load;
			end
			if (load) begin
				step_q <= last_d ? ST_HDR : step_d;
			end else if (q_not_empty && out_free) begin
				step_q <= ST_HDR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_d;
			ev_q    <= ev_d;
			start_q <= start_d;
			size_q  <= size_d;
			entry_q <= entry_d;
			hw_a_q  <= head_rec.hw_a;
			hw_b_q  <= head_rec.hw_b;
			hw_c_q  <= head_rec.hw_c;
			hw_d_q  <= head_rec.hw_d;
			last_q  <= last_d;
		end
	end

	assign out_valid      = valid_q;
	assign range_kind     = kind_q;
	assign range_evidence = ev_q;
	assign range_start    = start_q;
	assign range_size     = size_q;
	assign is_entry       = entry_q;
	assign header_word_a  = hw_a_q;
	assign header_word_b  = hw_b_q;
	assign header_word_c  = hw_c_q;
	assign header_word_d  = hw_d_q;
	assign last_range     = last_q;

endmodule

[design/code_segment_entry_scanner.sv]
// Code segment entry scanner: payload bytes in, up to three ranges out per payload.
// Throughput: one byte per cycle unless in_stall; one range beat per cycle unless out_stall.
// A payload's summary is registered in the queue, then each of its ranges in the output register.
// A four-entry summary queue decouples the byte scanner from the range emitter.
// Input stalls only while that queue is full; output beats wait in a single output register.
// Reset (arst_n low) clears the offset, header, match state, queue and output valid.
module code_segment_entry_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic signed [15:0] segment_id,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         range_kind,
	output logic [2:0]         range_evidence,
	output logic [31:0]        range_start,
	output logic [31:0]        range_size,
	output logic               is_entry,
	output logic [31:0]        header_word_a,
	output logic [31:0]        header_word_b,
	output logic [31:0]        header_word_c,
	output logic [31:0]        header_word_d,
	output logic               last_range
);

	csescan_pkg::seg_rec_t push_rec;
	csescan_pkg::seg_rec_t head_rec;
	csescan_pkg::q_ctrl_t  q_ctrl;
	csescan_pkg::q_stat_t  q_stat;
	logic                  push;
	logic                  pop;

	assign q_ctrl.push = push;
	assign q_ctrl.pop  = pop;

	csescan_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.segment_id (segment_id),
		.last_byte  (last_byte),
		.q_full     (q_stat.full),
		.push       (push),
		.push_rec   (push_rec)
	);

	csescan_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.push_rec (push_rec),
		.stat     (q_stat),
		.head_rec (head_rec)
	);

	csescan_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_stat.not_empty),
		.head_rec       (head_rec),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.range_kind     (range_kind),
		.range_evidence (range_evidence),
		.range_start    (range_start),
		.range_size     (range_size),
		.is_entry       (is_entry),
		.header_word_a  (header_word_a),
		.header_word_b  (header_word_b),
		.header_word_c  (header_word_c),
		.header_word_d  (header_word_d),
		.last_range     (last_range)
	);

endmodule
